// File: src/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants for the double-ended queue: default depth, word width,
// operation selectors and result status codes.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Default number of entries in the ring store.
  localparam int DEPTH_DEFAULT = 16;

  // Width of one stored word.
  localparam int WORD_W = 32;

  // Operation selector codes.
  localparam int FUNC_W = 3;
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DUMP       = 3'd4;

  // Result status codes.
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

endpackage

// File: src/dq_mem.sv
// ----------------------------------------------------------------------------
// dq_mem
// Entry store of the queue: one write port and one read port, with the read
// data registered, so a read returns its word in the cycle after it is issued.
// ----------------------------------------------------------------------------
module dq_mem #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [$clog2(DEPTH)-1:0]            waddr_i,
  input  logic signed [dq_pkg::WORD_W-1:0]    wdata_i,
  input  logic                                re_i,
  input  logic [$clog2(DEPTH)-1:0]            raddr_i,
  output logic signed [dq_pkg::WORD_W-1:0]    rdata_o
);

  logic signed [dq_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic signed [dq_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // The read data register holds its word until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit words held in a ring store with
// a front index and an entry count. Supports push and pop at either end and a
// dump that streams every entry from front to rear.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   input     in         in_valid_i / in_ready_o    func_i, value_in_i
//   output    out        out_valid_o / out_ready_i  value_out_o, status_o, last_o
//
// A push, an overflow, an underflow, an empty dump or an unused selector is
// settled in the cycle it is accepted: one item per cycle while results drain.
// A pop issues its read to the entry store and waits in the read state until
// the word is registered. During a dump, the next read is issued in the same
// cycle as the previous word is registered.
// Reset clears the state, the front index, the entry count, the dump progress
// and the output valid flag; the store itself is not cleared, as an entry is
// only read after it is written.
// A stall on the output holds the result register and, with it, the input.
//
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dq_pkg::FUNC_W-1:0]           func_i,
  input  logic signed [dq_pkg::WORD_W-1:0]    value_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [dq_pkg::WORD_W-1:0]    value_out_o,
  output logic [dq_pkg::STATUS_W-1:0]         status_o,
  output logic                                last_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  // Two states: ready for a new item, or waiting on the store's read data.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  // Ring position of the entry that lies a given distance behind the front.
  // The sum stays below twice the depth, so one compare and subtract wraps it.
  function automatic logic [IDX_W-1:0] wrap_slot(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Control state.
  logic             state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  // Dump progress: distance of the next entry to read, and reads still to go.
  logic [CNT_W-1:0] off_q, off_d;
  logic [CNT_W-1:0] left_q, left_d;

  // Output register.
  logic                             out_valid_q;
  logic signed [dq_pkg::WORD_W-1:0] value_out_q;
  logic [dq_pkg::STATUS_W-1:0]      status_q;
  logic                             last_q;

  // Store ports.
  logic                             mem_we;
  logic [IDX_W-1:0]                 mem_waddr;
  logic                             mem_re;
  logic [IDX_W-1:0]                 mem_raddr;
  logic signed [dq_pkg::WORD_W-1:0] mem_rdata;

  // Result to be registered this cycle.
  logic                             load;
  logic signed [dq_pkg::WORD_W-1:0] load_value;
  logic [dq_pkg::STATUS_W-1:0]      load_status;
  logic                             load_last;

  logic out_free;
  logic in_acc;
  logic is_full;
  logic is_empty;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_full    = (cnt_q == FULL_CNT);
  assign is_empty   = (cnt_q == '0);

  dq_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (value_in_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Writes and reads never fall in the same cycle, and an item is only taken
  // once the previous one has finished with the store, so every read sees all
  // earlier writes without any forwarding path.
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    cnt_d       = cnt_q;
    off_d       = off_q;
    left_d      = left_q;
    mem_we      = 1'b0;
    mem_waddr   = front_q;
    mem_re      = 1'b0;
    mem_raddr   = front_q;
    load        = 1'b0;
    load_value  = '0;
    load_status = dq_pkg::ST_OK;
    load_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (func_i)
            dq_pkg::FN_PUSH_FRONT: begin
              load = 1'b1;
              if (is_full) begin
                load_status = dq_pkg::ST_OVERFLOW;
              end else begin
                front_d   = (front_q == '0) ? LAST_SLOT : front_q - 1'b1;
                mem_we    = 1'b1;
                mem_waddr = front_d;
                cnt_d     = cnt_q + 1'b1;
              end
            end
            dq_pkg::FN_PUSH_BACK: begin
              load = 1'b1;
              if (is_full) begin
                load_status = dq_pkg::ST_OVERFLOW;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = wrap_slot(front_q, cnt_q);
                cnt_d     = cnt_q + 1'b1;
              end
            end
            dq_pkg::FN_POP_FRONT: begin
              if (is_empty) begin
                load        = 1'b1;
                load_status = dq_pkg::ST_UNDERFLOW;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_q;
                front_d   = (front_q == LAST_SLOT) ? '0 : front_q + 1'b1;
                cnt_d     = cnt_q - 1'b1;
                left_d    = '0;
                state_d   = S_READ;
              end
            end
            dq_pkg::FN_POP_BACK: begin
              if (is_empty) begin
                load        = 1'b1;
                load_status = dq_pkg::ST_UNDERFLOW;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = wrap_slot(front_q, cnt_q - 1'b1);
                cnt_d     = cnt_q - 1'b1;
                left_d    = '0;
                state_d   = S_READ;
              end
            end
            dq_pkg::FN_DUMP: begin
              if (is_empty) begin
                load        = 1'b1;
                load_status = dq_pkg::ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_q;
                off_d     = CNT_W'(1);
                left_d    = cnt_q - 1'b1;
                state_d   = S_READ;
              end
            end
            default: begin
              // Unused selectors are taken and dropped without a result.
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          load       = 1'b1;
          load_value = mem_rdata;
          load_last  = (left_q == '0);
          if (left_q != '0) begin
            mem_re    = 1'b1;
            mem_raddr = wrap_slot(front_q, off_q);
            off_d     = off_q + 1'b1;
            left_d    = left_q - 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      cnt_q       <= '0;
      off_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      cnt_q   <= cnt_d;
      off_q   <= off_d;
      left_q  <= left_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      value_out_q <= load_value;
      status_q    <= load_status;
      last_q      <= load_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = value_out_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

`ifndef NO_ASSERTIONS
  // The entry count never passes the capacity of the store.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT)
    else $error("entry count exceeds depth");

  // The front index stays within the ring, also for depths off a power of two.
  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SUM_W'(front_q) < SUM_W'(DEPTH))
    else $error("front index outside the ring");

  // A pop on a non-empty queue waits on the store and blocks the input.
  a_pop_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !is_empty &&
    (func_i == dq_pkg::FN_POP_FRONT || func_i == dq_pkg::FN_POP_BACK)
    |=> state_q == S_READ && !in_ready_o)
    else $error("pop did not wait for read data");

  // A push at the back on a queue with room grows the count by one.
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !is_full && func_i == dq_pkg::FN_PUSH_BACK
    |=> cnt_q == CNT_W'($past(cnt_q) + 1'b1))
    else $error("push did not grow the count");
`endif

endmodule

// File: verif/tb_double_ended_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the bounded double-ended queue. A scoreboard class
// keeps its own ring of words and predicts every result of each input
// transfer. Both channels stall at random, and the stimulus mixes fill, drain
// and balanced phases so that the queue runs empty and full many times.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;

  // The block is built with its default depth.
  localparam int DEPTH    = dq_pkg::DEPTH_DEFAULT;
  localparam int WORD_W   = dq_pkg::WORD_W;
  localparam int FUNC_W   = dq_pkg::FUNC_W;
  localparam int STATUS_W = dq_pkg::STATUS_W;
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);

  // Selector codes past the dump are unused: the block drops them silently.
  localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = dq_pkg::FN_DUMP + 1'b1;
  localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = '1;

  // Number of random transfers that produce results.
  localparam int RANDOM_ITEMS = 180;

  // Chance, in percent, that either side idles in a given cycle.
  localparam int IDLE_PCT = 37;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} load_mode_e;

  // One result as the block presents it on the output channel.
  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic [STATUS_W-1:0]      status;
    logic                     last;
  } deque_result_t;

  // Scoreboard: a private copy of the ring store, the front position and the
  // fill level, plus the results still owed by the block, oldest first.
  class deque_scoreboard;
    logic signed [WORD_W-1:0] slots [DEPTH];
    logic [PTR_W-1:0]         head;
    logic [CNT_W-1:0]         fill;
    deque_result_t            awaited [$];
    int mismatches;
    int items_seen;
    int results_seen;
    int dumps_seen;
    int overflows;
    int underflows;
    int peak_fill;

    function new();
      head = '0;
      fill = '0;
      mismatches = 0;
      items_seen = 0;
      results_seen = 0;
      dumps_seen = 0;
      overflows = 0;
      underflows = 0;
      peak_fill = 0;
    endfunction

    function logic [PTR_W-1:0] wrap(int unsigned pos);
      return PTR_W'(pos % DEPTH);
    endfunction

    function void owe(logic signed [WORD_W-1:0] word, logic [STATUS_W-1:0] status,
                      logic last);
      deque_result_t res;
      res.word = word;
      res.status = status;
      res.last = last;
      awaited.push_back(res);
    endfunction

    // Called for every accepted input transfer, in order of acceptance.
    function void note_input(logic [FUNC_W-1:0] func, logic signed [WORD_W-1:0] word);
      if (func > dq_pkg::FN_DUMP) return;
      items_seen++;
      case (func)
        dq_pkg::FN_PUSH_FRONT, dq_pkg::FN_PUSH_BACK: begin
          if (fill == DEPTH) begin
            overflows++;
            owe('0, dq_pkg::ST_OVERFLOW, 1'b1);
          end else begin
            if (func == dq_pkg::FN_PUSH_FRONT) begin
              head = wrap(head + DEPTH - 1);
              slots[head] = word;
            end else begin
              slots[wrap(head + fill)] = word;
            end
            fill++;
            if (fill > peak_fill) peak_fill = fill;
            owe('0, dq_pkg::ST_OK, 1'b1);
          end
        end
        dq_pkg::FN_POP_FRONT, dq_pkg::FN_POP_BACK: begin
          if (fill == 0) begin
            underflows++;
            owe('0, dq_pkg::ST_UNDERFLOW, 1'b1);
          end else if (func == dq_pkg::FN_POP_FRONT) begin
            owe(slots[head], dq_pkg::ST_OK, 1'b1);
            head = wrap(head + 1);
            fill--;
          end else begin
            owe(slots[wrap(head + fill - 1)], dq_pkg::ST_OK, 1'b1);
            fill--;
          end
        end
        default: begin
          dumps_seen++;
          if (fill == 0) begin
            owe('0, dq_pkg::ST_EMPTY, 1'b1);
          end else begin
            for (int i = 0; i < fill; i++) begin
              owe(slots[wrap(head + i)], dq_pkg::ST_OK, (i == fill - 1));
            end
          end
        end
      endcase
    endfunction

    // Called for every accepted output transfer.
    function void check_result(logic signed [WORD_W-1:0] word, logic [STATUS_W-1:0] status,
                               logic last);
      deque_result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        $error("unexpected result: value_out %0d status %0d last %0d", word, status, last);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (word !== want.word) begin
        $error("value_out: expected %0d, got %0d", want.word, word);
        mismatches++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  // All inputs of the block hold known values from time zero.
  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [FUNC_W-1:0]        func_i = dq_pkg::FN_PUSH_FRONT;
  logic signed [WORD_W-1:0] value_in_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [WORD_W-1:0] value_out_o;
  logic [STATUS_W-1:0]      status_o;
  logic                     last_o;

  // While set, neither side inserts idle cycles.
  logic no_gaps = 1'b0;

  deque_scoreboard book = new();

  double_ended_queue #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .value_in_i (value_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_out_o(value_out_o),
    .status_o   (status_o),
    .last_o     (last_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // A hard ceiling on the run. The slowest legal run (every transfer causing
  // a full dump, every result held up by a long stall) stays well inside it.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // The receiver lowers ready at random, except during the gap-free stretch.
  always @(posedge clk_i) begin
    out_ready_i <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Both channels are sampled at the same edge. Every signal read here holds
  // its value from before the edge, so the order of processes does not matter.
  // The input transfer is noted before the output one so that even a result
  // produced in the cycle of its own input would find its prediction waiting.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      book.note_input(func_i, value_in_i);
    end
    if (out_valid_o && out_ready_i) begin
      book.check_result(value_out_o, status_o, last_o);
    end
  end

  // Presents one item and returns at the edge where it is transferred. Idle
  // cycles before it are drawn at random. Valid is only ever assigned once
  // per time step: it is either dropped for a gap or kept high for the item.
  task automatic send_item(logic [FUNC_W-1:0] func, logic signed [WORD_W-1:0] word);
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= func;
    value_in_i <= word;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin
    logic signed [WORD_W-1:0] corner_words [4];
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] word;
    load_mode_e               mode;
    int                       push_pct;
    int                       seg_len;
    int                       sent;
    int                       pick;

    corner_words[0] = 32'sh8000_0000;
    corner_words[1] = 32'sh7FFF_FFFF;
    corner_words[2] = '0;
    corner_words[3] = -32'sd1;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening. On the empty queue both pops must underflow and a
    // dump must report an empty queue; unused selectors must leave no trace.
    send_item(dq_pkg::FN_POP_FRONT, 32'sd17);
    send_item(dq_pkg::FN_POP_BACK, -32'sd17);
    send_item(dq_pkg::FN_DUMP, '0);
    for (int s = FN_SPARE_FIRST; s <= FN_SPARE_LAST; s++) begin
      send_item(FUNC_W'(s), $urandom);
    end

    // Fill the queue from both ends, starting with the extreme words, then
    // push at each end while full, dump all entries and pop once at each end.
    for (int i = 0; i < DEPTH; i++) begin
      word = (i < 4) ? corner_words[i] : (i == 4) ? 32'shAAAA_AAAA :
             (i == 5) ? 32'sh5555_5555 : $urandom;
      send_item(i[0] ? dq_pkg::FN_PUSH_BACK : dq_pkg::FN_PUSH_FRONT, word);
    end
    send_item(dq_pkg::FN_PUSH_FRONT, 32'sh1234_5678);
    send_item(dq_pkg::FN_PUSH_BACK, -32'sd2);
    send_item(dq_pkg::FN_DUMP, '0);
    send_item(dq_pkg::FN_POP_FRONT, '0);
    send_item(dq_pkg::FN_POP_BACK, '0);

    // Random part, in segments with a push bias that drives the queue
    // towards full, towards empty, or keeps it wandering. One stretch in the
    // middle runs without idle cycles on either side.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(8, 28);
      mode = load_mode_e'($urandom_range(0, 2));
      push_pct = (mode == MODE_FILL) ? 80 : (mode == MODE_DRAIN) ? 20 : 50;
      no_gaps <= (sent >= 90 && sent < 140);
      for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          func = FUNC_W'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
        end else if (pick < 11) begin
          func = dq_pkg::FN_DUMP;
        end else if ($urandom_range(0, 99) < push_pct) begin
          func = $urandom_range(0, 1) ? dq_pkg::FN_PUSH_BACK : dq_pkg::FN_PUSH_FRONT;
        end else begin
          func = $urandom_range(0, 1) ? dq_pkg::FN_POP_BACK : dq_pkg::FN_POP_FRONT;
        end
        word = ($urandom_range(0, 7) == 0) ? corner_words[$urandom_range(0, 3)] : $urandom;
        send_item(func, word);
        if (func <= dq_pkg::FN_DUMP) sent++;
      end
    end
    in_valid_i <= 1'b0;
    no_gaps <= 1'b0;

    // Drain: wait for every owed result, then allow a few more cycles so that
    // any stray result still in the block would show up as unexpected.
    while (book.awaited.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);

    if (book.awaited.size() != 0) begin
      $error("%0d results never arrived", book.awaited.size());
    end
    $display("Run covered %0d input transfers and %0d checked results.",
             book.items_seen, book.results_seen);
    $display("It held %0d dumps, %0d overflows, %0d underflows, peak %0d of %0d.",
             book.dumps_seen, book.overflows, book.underflows, book.peak_fill, DEPTH);
    if (book.mismatches == 0 && book.awaited.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
